FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers: active in simulation, empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check, masked while reset is asserted
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs through reset
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_RST(lbl, prop, msg)

`endif

`endif

FILE: rtl/fbd_pkg.sv
// ----------------------------------------------------------------------------
// fbd_pkg
// Constants, tables and helper functions for the 16-bit Feistel decryptor.
// ----------------------------------------------------------------------------
package fbd_pkg;

  localparam int unsigned BLK_W  = 16;
  localparam int unsigned HALF_W = 8;
  localparam int unsigned KEY_W  = 12;
  localparam int unsigned ROUNDS = 4;

  typedef logic [BLK_W-1:0]  blk_t;
  typedef logic [HALF_W-1:0] half_t;
  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [4:0]        perm_tbl_t [BLK_W];

  // Per-round left rotation of the key, always from the configured key
  localparam int unsigned ROT_SCHED [4] = '{6, 4, 2, 1};

  // Bit tables numbered 1..16 from the MSB; output bit i takes input bit tbl[i]
  localparam perm_tbl_t PERM_FWD = '{5'd8, 5'd13, 5'd4, 5'd9, 5'd16, 5'd5, 5'd12, 5'd1,
                                     5'd7, 5'd14, 5'd3, 5'd10, 5'd15, 5'd6, 5'd11, 5'd2};
  localparam perm_tbl_t PERM_INV = '{5'd8, 5'd16, 5'd11, 5'd3, 5'd6, 5'd14, 5'd9, 5'd1,
                                     5'd4, 5'd12, 5'd15, 5'd7, 5'd2, 5'd10, 5'd13, 5'd5};

  // Shared 4x16 S-box, row-major
  localparam logic [3:0] SBOX [64] = '{
    4'd14, 4'd4,  4'd13, 4'd1,  4'd2,  4'd15, 4'd11, 4'd8,
    4'd3,  4'd10, 4'd6,  4'd12, 4'd5,  4'd9,  4'd0,  4'd7,
    4'd0,  4'd15, 4'd7,  4'd4,  4'd14, 4'd2,  4'd13, 4'd1,
    4'd10, 4'd6,  4'd12, 4'd11, 4'd9,  4'd5,  4'd3,  4'd8,
    4'd4,  4'd1,  4'd14, 4'd8,  4'd13, 4'd6,  4'd2,  4'd11,
    4'd15, 4'd12, 4'd9,  4'd7,  4'd3,  4'd10, 4'd5,  4'd0,
    4'd15, 4'd12, 4'd8,  4'd2,  4'd4,  4'd9,  4'd1,  4'd7,
    4'd5,  4'd11, 4'd3,  4'd14, 4'd10, 4'd0,  4'd6,  4'd13};

  // Fixed bit permutation of a block
  function automatic blk_t permute16(input blk_t x, input perm_tbl_t tbl);
    blk_t       y;
    logic [3:0] src;
    y = '0;
    for (int i = 0; i < BLK_W; i++) begin
      src = 4'(5'd16 - tbl[i]);
      y[BLK_W-1-i] = x[src];
    end
    return y;
  endfunction

  // 12-bit rotate left by a constant amount
  function automatic key_t rotl_key(input key_t k, input int unsigned n);
    logic [2*KEY_W-1:0] d;
    d = {k, k} << n;
    return d[2*KEY_W-1:KEY_W];
  endfunction

  // Row from outer bits, column from the middle four
  function automatic logic [3:0] sbox6(input logic [5:0] v);
    return SBOX[{v[5], v[0], v[4:1]}];
  endfunction

endpackage

FILE: rtl/feistel16_block_decrypt.sv
// ----------------------------------------------------------------------------
// feistel16_block_decrypt
// 16-bit block decryptor with a 12-bit key, one word per cycle when not stalled.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+---------------------------
//  in_     | input     | in_valid/in_stall  | in_cipher_block   [15:0]
//  out_    | output    | out_valid/out_stall| out_plain_block   [15:0]
//  cfg_    | input     | cfg_we             | cfg_cipher_key    [11:0]
//
//  A word passes the input register, then all rounds in one pass into
//  the result register. One word is taken every cycle unless in_stall is
//  high; the round chain sets the clock period. Synchronous reset clears
//  the valid flags and the key. A stall on the result side backs up into
//  in_stall in the same cycle once both registers hold a word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module feistel16_block_decrypt
  import fbd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  blk_t in_cipher_block,
  output logic out_valid,
  input  logic out_stall,
  output blk_t out_plain_block,
  input  logic cfg_we,
  input  key_t cfg_cipher_key
);

  key_t cipher_key_r;
  logic s1_valid_r, s1_valid_nxt;
  blk_t s1_block_r;
  logic out_valid_r, out_valid_nxt;
  blk_t out_block_r;
  logic s2_adv;
  blk_t plain_w;

  // Key register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cipher_key_r <= '0;
    end else if (cfg_we) begin
      cipher_key_r <= cfg_cipher_key;
    end
  end

  // Pipeline advance
  assign s2_adv   = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s2_adv;

  always_comb begin
    s1_valid_nxt  = in_stall ? s1_valid_r : in_valid;
    out_valid_nxt = s2_adv ? s1_valid_r : out_valid_r;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_block_r <= in_cipher_block;
    end
  end

  // Decrypt
  fbd_datapath u_datapath (
    .blk_in  (s1_block_r),
    .key     (cipher_key_r),
    .blk_out (plain_w)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid_r) begin
      out_block_r <= plain_w;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_plain_block = out_block_r;

  // Checks
  `ASSERT_RST(a_reset_clears, !rst_n |=> !s1_valid_r && !out_valid_r, "valid after reset")
  `ASSERT_CLK(a_in_lands, in_valid && !in_stall |=> s1_valid_r, "accepted word lost")
  `ASSERT_CLK(a_moves_on, s1_valid_r && s2_adv |=> out_valid_r, "word not passed on")
  `ASSERT_CLK(a_s1_holds, s1_valid_r && !s2_adv |=> s1_valid_r && $stable(s1_block_r),
              "held word changed")

endmodule

FILE: rtl/fbd_round.sv
// ----------------------------------------------------------------------------
// fbd_round
// Feistel round function: expand the right half, mix in the key, substitute.
// ----------------------------------------------------------------------------
module fbd_round
  import fbd_pkg::*;
(
  input  half_t right,
  input  key_t  round_key,
  output half_t f_out
);

  key_t expd;
  key_t mixed;

  // Expansion {r0,r6,r7..r0,r7,r1}, then key mix
  assign expd  = {right[0], right[6], right, right[7], right[1]};
  assign mixed = expd ^ round_key;

  // Two S-box lookups, upper half gives the upper nibble
  assign f_out = {sbox6(mixed[11:6]), sbox6(mixed[5:0])};

endmodule

FILE: rtl/fbd_datapath.sv
// ----------------------------------------------------------------------------
// fbd_datapath
// Single-pass decrypt: initial permutation, unrolled rounds, inverse permutation.
// ----------------------------------------------------------------------------
module fbd_datapath
  import fbd_pkg::*;
(
  input  blk_t blk_in,
  input  key_t key,
  output blk_t blk_out
);

  blk_t  ip_blk;
  half_t left_s  [ROUNDS+1];
  half_t right_s [ROUNDS+1];

  // Initial permutation and split
  assign ip_blk     = permute16(blk_in, PERM_FWD);
  assign left_s[0]  = ip_blk[BLK_W-1:HALF_W];
  assign right_s[0] = ip_blk[HALF_W-1:0];

  // One round stage per schedule entry
  for (genvar i = 0; i < ROUNDS; i++) begin : g_round
    half_t f;

    fbd_round u_round (
      .right     (right_s[i]),
      .round_key (rotl_key(key, ROT_SCHED[i % 4])),
      .f_out     (f)
    );

    if (i == ROUNDS - 1) begin : g_last
      // final round keeps the halves in place
      assign left_s[i+1]  = left_s[i] ^ f;
      assign right_s[i+1] = right_s[i];
    end else begin : g_swap
      assign left_s[i+1]  = right_s[i];
      assign right_s[i+1] = left_s[i] ^ f;
    end
  end

  // Inverse permutation
  assign blk_out = permute16({left_s[ROUNDS], right_s[ROUNDS]}, PERM_INV);

endmodule
